// File: hw/rtl/mafs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mafs_pkg: shared types, tables and field codes for the frame size block
// Holds the bitrate, sampling rate and coefficient tables, and the beat
// structs that travel down the decode, multiply and divide chain.
// ----------------------------------------------------------------------------
package mafs_pkg;

	localparam int Q_W     = 12;           // quotient bits, one per divide cell
	localparam int DIV_W   = 16;           // sampling rate in Hz
	localparam int NUM_W   = 26;           // coefficient * bitrate in bit/s
	localparam int CMP_W   = DIV_W + Q_W;  // widest shifted divisor
	localparam int KBPS_W  = 9;
	localparam int COEFK_W = 18;           // coefficient * 1000
	localparam int LEN_W   = 12;

	localparam logic [10:0] SYNC_ALL  = 11'h7FF;
	localparam logic [1:0]  VER_RSVD  = 2'd1;
	localparam logic [1:0]  VER_MPEG1 = 2'd3;
	localparam logic [1:0]  LAY_RSVD  = 2'd0;
	localparam logic [1:0]  LAY_ONE   = 2'd3;
	localparam logic [1:0]  LAY_TWO   = 2'd2;
	localparam logic [1:0]  SRI_RSVD  = 2'd3;
	localparam logic [3:0]  BRI_BAD   = 4'hF;
	localparam logic [3:0]  BRI_FREE  = 4'h0;
	localparam logic [1:0]  LI_ONE    = 2'd0;
	localparam logic [1:0]  LI_TWO    = 2'd1;
	localparam logic [1:0]  LI_THREE  = 2'd2;

	// kbit/s by low-rate flag, layer index and bitrate index
	localparam logic [KBPS_W-1:0] KBPS_TAB [0:1][0:2][0:14] = '{
		'{
			'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
			  9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
			'{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
			  9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320}
		},
		'{
			'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
			  9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
			'{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
			  9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160}
		}
	};

	// Hz by version code and sampling index
	localparam logic [DIV_W-1:0] RATE_TAB [0:3][0:2] = '{
		'{16'd11025, 16'd12000, 16'd8000},
		'{16'd0, 16'd0, 16'd0},
		'{16'd22050, 16'd24000, 16'd16000},
		'{16'd44100, 16'd48000, 16'd32000}
	};

	// Coefficient times 1000, by low-rate flag and layer index
	localparam logic [COEFK_W-1:0] COEFK_TAB [0:1][0:2] = '{
		'{18'd12000, 18'd144000, 18'd144000},
		'{18'd12000, 18'd144000, 18'd72000}
	};

	typedef struct packed {
		logic             hdr_ok;   // sync and indices legal
		logic             len_ok;   // legal and not free format
		logic             pad;
		logic             slot4;    // Layer I: four-byte slots
		logic [DIV_W-1:0] fs;
	} mafs_ctl_t;

	typedef struct packed {
		mafs_ctl_t          ctl;
		logic [KBPS_W-1:0]  kbps;
		logic [COEFK_W-1:0] coefk;
	} mafs_dec_t;

	typedef struct packed {
		mafs_ctl_t        ctl;
		logic [NUM_W-1:0] rem;
		logic [Q_W-1:0]   quo;
	} mafs_div_t;

	function automatic logic [1:0] layer_idx(input logic [1:0] lay);
		logic [1:0] li;
		case (lay)
			LAY_ONE: li = LI_ONE;
			LAY_TWO: li = LI_TWO;
			default: li = LI_THREE;
		endcase
		return li;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mafs_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mafs_decode: header check and table lookup stage
// Splits the header word, checks sync and reserved codes and registers the
// table values that the multiply and divide stages need.
// ----------------------------------------------------------------------------
module mafs_decode (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_v,
	input  wire [31:0]             header_word,
	output logic                   up_rdy,
	output logic                   out_v,
	output mafs_pkg::mafs_dec_t    out_d,
	input  wire                    dn_rdy
);
	import mafs_pkg::*;

	logic [10:0] sync_f;
	logic [1:0]  ver_f;
	logic [1:0]  lay_f;
	logic [3:0]  bri_f;
	logic [1:0]  sri_f;
	logic        lsf;
	logic [1:0]  li;
	logic        ok;
	mafs_dec_t   dec;
	logic        v_q;
	mafs_dec_t   d_s1;

	always_comb begin
		sync_f = header_word[31:21];
		ver_f  = header_word[20:19];
		lay_f  = header_word[18:17];
		bri_f  = header_word[15:12];
		sri_f  = header_word[11:10];
		lsf    = (ver_f != VER_MPEG1);
		li     = layer_idx(lay_f);
		ok     = (sync_f == SYNC_ALL) && (ver_f != VER_RSVD) && (lay_f != LAY_RSVD) &&
		         (bri_f != BRI_BAD) && (sri_f != SRI_RSVD);
		dec.ctl.hdr_ok = ok;
		dec.ctl.len_ok = ok && (bri_f != BRI_FREE);
		dec.ctl.pad    = header_word[9];
		dec.ctl.slot4  = (li == LI_ONE);
		// Out-of-range indices only occur on rejected headers; clamp them.
		dec.ctl.fs     = (sri_f == SRI_RSVD) ? '0 : RATE_TAB[ver_f][sri_f];
		dec.kbps       = (bri_f == BRI_BAD) ? '0 : KBPS_TAB[lsf][li][bri_f];
		dec.coefk      = COEFK_TAB[lsf][li];
	end

	assign up_rdy = !v_q || dn_rdy;
	assign out_v  = v_q;
	assign out_d  = d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_rdy) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (up_rdy && in_v) begin
			d_s1 <= dec;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mafs_div_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mafs_div_cell: one restoring-division cell
// Tries the divisor shifted by BIT against the running remainder, sets that
// quotient bit and hands the beat to the next cell.
// ----------------------------------------------------------------------------
module mafs_div_cell #(
	parameter int BIT = 0
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_v,
	input  mafs_pkg::mafs_div_t    in_d,
	output logic                   up_rdy,
	output logic                   out_v,
	output mafs_pkg::mafs_div_t    out_d,
	input  wire                    dn_rdy
);
	import mafs_pkg::*;

	logic [CMP_W-1:0] rem_x;
	logic [CMP_W-1:0] dsh;
	logic             ge;
	mafs_div_t        nxt;
	logic             v_q;
	mafs_div_t        d_q;

	always_comb begin
		rem_x = CMP_W'(in_d.rem);
		dsh   = CMP_W'(in_d.ctl.fs) << BIT;
		ge    = (rem_x >= dsh);
		nxt   = in_d;
		if (ge) begin
			nxt.rem      = NUM_W'(rem_x - dsh);
			nxt.quo[BIT] = 1'b1;
		end
	end

	assign up_rdy = !v_q || dn_rdy;
	assign out_v  = v_q;
	assign out_d  = d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_rdy) begin
			v_q <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (up_rdy && in_v) begin
			d_q <= nxt;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mpeg_audio_frame_size.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mpeg_audio_frame_size: MPEG audio header check and frame length
// Checks one 32-bit frame header per beat and returns its validity and the
// frame length in bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel word_*: one header per beat, first stream byte in
//   header_word[31:24]. A beat moves when word_valid is high and word_stall
//   is low.
//   Output channel size_*: one beat per header, in order, carrying
//   header_valid and frame_bytes (0 for a bad or free-format header).
//   Pipeline: decode/table stage, bitrate multiply stage, twelve division
//   cells (one quotient bit each), output register.
//   Throughput is one header per cycle while size_stall is low; the division
//   chain is fully pipelined; the twelve cells set the latency, not the rate.
//   When the receiver stalls, the output register holds its beat and each
//   stage keeps filling until the chain is full; only then does word_stall
//   rise. Bubbles in the chain are squeezed out.
//   Reset clears every valid bit; the data registers are not reset.
// ----------------------------------------------------------------------------
module mpeg_audio_frame_size (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        word_valid,
	output logic                       word_stall,
	input  wire [31:0]                 header_word,
	output logic                       size_valid,
	input  wire                        size_stall,
	output logic                       header_valid,
	output logic [mafs_pkg::LEN_W-1:0] frame_bytes
);
	import mafs_pkg::*;

	logic             dec_v;
	mafs_dec_t        dec_d;
	logic             dec_rdy;

	logic             v_s2;
	mafs_div_t        d_s2;
	logic             rdy_s2;

	// stage k feeds cell k; index Q_W is the last cell's output
	logic             chain_v   [0:Q_W];
	mafs_div_t        chain_d   [0:Q_W];
	logic             chain_rdy [0:Q_W];

	logic             out_v_q;
	logic             hv_q;
	logic [LEN_W-1:0] len_q;
	logic             out_rdy;

	mafs_div_t        fin;
	logic [Q_W:0]     slots;
	logic [LEN_W-1:0] len_nxt;

	// Decode and table lookup
	mafs_decode u_dec (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_v        (word_valid),
		.header_word (header_word),
		.up_rdy      (dec_rdy),
		.out_v       (dec_v),
		.out_d       (dec_d),
		.dn_rdy      (rdy_s2)
	);

	assign word_stall = !dec_rdy;

	// Multiply: bitrate in kbit/s times coefficient*1000 gives the dividend
	assign rdy_s2 = !v_s2 || chain_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= dec_v;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && dec_v) begin
			d_s2.ctl <= dec_d.ctl;
			d_s2.rem <= NUM_W'(dec_d.kbps) * NUM_W'(dec_d.coefk);
			d_s2.quo <= '0;
		end
	end

	assign chain_v[0] = v_s2;
	assign chain_d[0] = d_s2;

	// Division chain: most significant quotient bit first
	for (genvar g = 0; g < Q_W; g++) begin : g_div
		mafs_div_cell #(
			.BIT (Q_W - 1 - g)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.in_v   (chain_v[g]),
			.in_d   (chain_d[g]),
			.up_rdy (chain_rdy[g]),
			.out_v  (chain_v[g+1]),
			.out_d  (chain_d[g+1]),
			.dn_rdy (chain_rdy[g+1])
		);
	end

	// Output: add padding slot, scale by slot size, zero for bad/free headers
	assign chain_rdy[Q_W] = out_rdy;
	assign out_rdy        = !out_v_q || !size_stall;

	always_comb begin
		fin   = chain_d[Q_W];
		slots = {1'b0, fin.quo} + (Q_W+1)'(fin.ctl.pad);
		if (!fin.ctl.len_ok) begin
			len_nxt = '0;
		end else if (fin.ctl.slot4) begin
			len_nxt = LEN_W'(slots << 2);
		end else begin
			len_nxt = LEN_W'(slots);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_rdy) begin
			out_v_q <= chain_v[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (out_rdy && chain_v[Q_W]) begin
			hv_q  <= fin.ctl.hdr_ok;
			len_q <= len_nxt;
		end
	end

	assign size_valid   = out_v_q;
	assign header_valid = hv_q;
	assign frame_bytes  = len_q;

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		size_valid && !header_valid |-> frame_bytes == '0)
		else $error("rejected header with nonzero length");

	a_len_max: assert property (@(posedge clk) disable iff (!arst_n)
		size_valid |-> frame_bytes <= LEN_W'(2881))
		else $error("frame length above largest legal frame");

	a_no_early_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!dec_v |-> !word_stall)
		else $error("input stalled with decode stage empty");

	a_hold_until_full: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s2 |-> !word_stall)
		else $error("input stalled with multiply stage empty");
`endif

endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for mpeg_audio_frame_size
// Drives 32-bit frame headers through the word channel and checks each size
// beat against a frame length calculation kept in the bench. Both channels
// idle and stall at random, and the sender drains the block now and then.
// ----------------------------------------------------------------------------
module tb;

	localparam int LEN_W = mafs_pkg::LEN_W;

	// Header field codes
	localparam logic [10:0] SYNC_ONES = 11'h7FF;
	localparam logic [1:0]  VER_25    = 2'd0;
	localparam logic [1:0]  VER_BAD   = 2'd1;
	localparam logic [1:0]  VER_2     = 2'd2;
	localparam logic [1:0]  VER_1     = 2'd3;
	localparam logic [1:0]  LAYER_BAD = 2'd0;
	localparam logic [1:0]  LAYER_3   = 2'd1;
	localparam logic [1:0]  LAYER_2   = 2'd2;
	localparam logic [1:0]  LAYER_1   = 2'd3;
	localparam logic [1:0]  SR_44K    = 2'd0;   // 44.1 kHz at MPEG-1, scaled down below
	localparam logic [1:0]  SR_48K    = 2'd1;
	localparam logic [1:0]  SR_32K    = 2'd2;
	localparam logic [1:0]  SR_BAD    = 2'd3;
	localparam logic [3:0]  BRI_FREE  = 4'h0;
	localparam logic [3:0]  BRI_BAD   = 4'hF;

	localparam int RAND_HEADERS = 400;
	localparam int END_WAIT     = 40;     // margin past the pipeline depth
	localparam int IDLE_LIMIT   = 3000;   // cycles with no beat on either side

	typedef struct packed {
		logic             ok;
		logic [LEN_W-1:0] bytes;
	} frame_size_t;

	// ------------------------------------------------------------------------
	// Frame length scoreboard: predict each accepted header and hold the
	// expected sizes in arrival order.
	// ------------------------------------------------------------------------
	class frame_len_board;
		frame_size_t expected_sizes[$];
		int          errors;

		// Bitrates in kbit/s for one bitrate index, five 9-bit columns, LSB first:
		// MPEG-1 L1, MPEG-1 L2, MPEG-1 L3, low-rate L1, low-rate L2/L3.
		function logic [44:0] kbit_row(logic [3:0] bri);
			case (bri)
				4'd1:    return {9'd8,   9'd32,  9'd32,  9'd32,  9'd32};
				4'd2:    return {9'd16,  9'd48,  9'd40,  9'd48,  9'd64};
				4'd3:    return {9'd24,  9'd56,  9'd48,  9'd56,  9'd96};
				4'd4:    return {9'd32,  9'd64,  9'd56,  9'd64,  9'd128};
				4'd5:    return {9'd40,  9'd80,  9'd64,  9'd80,  9'd160};
				4'd6:    return {9'd48,  9'd96,  9'd80,  9'd96,  9'd192};
				4'd7:    return {9'd56,  9'd112, 9'd96,  9'd112, 9'd224};
				4'd8:    return {9'd64,  9'd128, 9'd112, 9'd128, 9'd256};
				4'd9:    return {9'd80,  9'd144, 9'd128, 9'd160, 9'd288};
				4'd10:   return {9'd96,  9'd160, 9'd160, 9'd192, 9'd320};
				4'd11:   return {9'd112, 9'd176, 9'd192, 9'd224, 9'd352};
				4'd12:   return {9'd128, 9'd192, 9'd224, 9'd256, 9'd384};
				4'd13:   return {9'd144, 9'd224, 9'd256, 9'd320, 9'd416};
				4'd14:   return {9'd160, 9'd256, 9'd320, 9'd384, 9'd448};
				default: return '0;
			endcase
		endfunction

		// MPEG-1 rate, halved for MPEG-2 and quartered for MPEG-2.5
		function longint sample_hz(logic [1:0] ver, logic [1:0] sri);
			longint base;
			case (sri)
				SR_44K:  base = 44100;
				SR_48K:  base = 48000;
				default: base = 32000;
			endcase
			case (ver)
				VER_1:   return base;
				VER_2:   return base / 2;
				default: return base / 4;
			endcase
		endfunction

		function frame_size_t predict_size(logic [31:0] w);
			logic [1:0]  ver;
			logic [1:0]  lay;
			logic [1:0]  sri;
			logic [3:0]  bri;
			logic        pad;
			logic        lsf;
			logic [44:0] row;
			int          col;
			longint      kbit;
			longint      coef;
			longint      slot;
			longint      len;
			frame_size_t r;
			ver = w[20:19];
			lay = w[18:17];
			bri = w[15:12];
			sri = w[11:10];
			pad = w[9];
			r.ok = (w[31:21] == SYNC_ONES) && (ver != VER_BAD) && (lay != LAYER_BAD) &&
			       (bri != BRI_BAD) && (sri != SR_BAD);
			r.bytes = '0;
			// Free format is legal but has no table bitrate: length stays 0
			if (r.ok && bri != BRI_FREE) begin
				lsf = (ver != VER_1);
				if (lsf)
					col = (lay == LAYER_1) ? 3 : 4;
				else
					col = (lay == LAYER_1) ? 0 : (lay == LAYER_2) ? 1 : 2;
				row  = kbit_row(bri);
				kbit = row[col*9 +: 9];
				if (lay == LAYER_1)
					coef = 12;
				else if (lsf && lay == LAYER_3)
					coef = 72;
				else
					coef = 144;
				slot = (lay == LAYER_1) ? 4 : 1;
				len = ((coef * kbit * 1000) / sample_hz(ver, sri) + pad) * slot;
				r.bytes = len[LEN_W-1:0];
			end
			return r;
		endfunction

		function void note_header(logic [31:0] w);
			expected_sizes.push_back(predict_size(w));
		endfunction

		function void check_size(logic ok, logic [LEN_W-1:0] bytes);
			frame_size_t want;
			if (expected_sizes.size() == 0) begin
				$error("size beat with no header pending: header_valid %0d frame_bytes %0d",
				       ok, bytes);
				errors++;
				return;
			end
			want = expected_sizes.pop_front();
			if (ok !== want.ok) begin
				$error("header_valid: expected %0d, actual %0d", want.ok, ok);
				errors++;
			end
			if (bytes !== want.bytes) begin
				$error("frame_bytes: expected %0d, actual %0d", want.bytes, bytes);
				errors++;
			end
		endfunction

		function int pending();
			return expected_sizes.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and DUT
	// ------------------------------------------------------------------------
	logic             clk = 1'b0;
	logic             arst_n;
	logic             word_valid;
	logic             word_stall;
	logic [31:0]      header_word;
	logic             size_valid;
	logic             size_stall;
	logic             header_valid;
	logic [LEN_W-1:0] frame_bytes;

	frame_len_board board;
	bit             calm;          // when set, neither side idles or stalls
	int             idle_cycles;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	mpeg_audio_frame_size u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.word_valid   (word_valid),
		.word_stall   (word_stall),
		.header_word  (header_word),
		.size_valid   (size_valid),
		.size_stall   (size_stall),
		.header_valid (header_valid),
		.frame_bytes  (frame_bytes)
	);

	// ------------------------------------------------------------------------
	// Monitors: sample both channels at the rising edge, before the DUT's
	// registers move, so the values seen are the ones the edge accepted.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (word_valid === 1'b1 && word_stall === 1'b0)
			board.note_header(header_word);
		if (size_valid === 1'b1 && size_stall === 1'b0)
			board.check_size(header_valid, frame_bytes);
	end

	// Count cycles with no beat on either channel; reset on any beat
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((word_valid === 1'b1 && word_stall === 1'b0) ||
		             (size_valid === 1'b1 && size_stall === 1'b0)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Watchdog: give up once the block has gone quiet for too long
	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("mpeg_audio_frame_size test failed");
		$finish;
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Receiver: raise size_stall for random stretches. Each change lands on a
	// falling edge, and size_stall drops after every stall before the next one starts.
	// ------------------------------------------------------------------------
	initial begin : size_stall_gen
		int stall_len;
		size_stall = 1'b0;
		@(negedge clk);
		forever begin
			stall_len = calm ? 0 : pick_gap();
			if (stall_len != 0) begin
				size_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
				size_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 24)) @(negedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// Sender tasks. Each is entered and left on a falling edge.
	// ------------------------------------------------------------------------

	// Present one header, hold it until accepted, then idle a random gap.
	// valid stays high straight into the next beat when the gap is zero.
	task automatic send_header(logic [31:0] w);
		int gap;
		word_valid  <= 1'b1;
		header_word <= w;
		do
			@(posedge clk);
		while (word_stall !== 1'b0);
		@(negedge clk);
		gap = calm ? 0 : pick_gap();
		if (gap != 0) begin
			word_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	// Drop valid and hold off until every expected size has come back
	task automatic drain_sizes();
		word_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Legal sync and the given fields; protection bit and low nine bits are random
	function automatic logic [31:0] build_header(logic [1:0] ver, logic [1:0] lay,
	                                             logic [3:0] bri, logic [1:0] sri,
	                                             logic pad);
		logic [31:0] junk;
		junk = $urandom;
		return {SYNC_ONES, ver, lay, junk[16], bri, sri, pad, junk[8:0]};
	endfunction

	// Random header: mostly well-formed, some with one bad field, some noise
	function automatic logic [31:0] rand_header();
		logic [1:0]  ver;
		logic [1:0]  lay;
		logic [3:0]  bri;
		logic [1:0]  sri;
		logic [31:0] w;
		int          mode;
		int          v;
		mode = $urandom_range(0, 9);
		if (mode == 0)
			return $urandom;
		v   = $urandom_range(0, 2);
		ver = (v == 0) ? VER_25 : (v == 1) ? VER_2 : VER_1;
		lay = 2'($urandom_range(1, 3));
		bri = 4'($urandom_range(0, 14));
		sri = 2'($urandom_range(0, 2));
		if (mode == 1) begin
			// Break at most one thing
			case ($urandom_range(0, 4))
				0:       ver = VER_BAD;
				1:       lay = LAYER_BAD;
				2:       bri = BRI_BAD;
				3:       sri = SR_BAD;
				default: ;
			endcase
		end
		w = build_header(ver, lay, bri, sri, 1'($urandom_range(0, 1)));
		// Rarely flip one sync bit as well
		if (mode == 1 && w[31:21] == SYNC_ONES && $urandom_range(0, 4) == 0)
			w[31:21] = w[31:21] ^ (11'h1 << $urandom_range(0, 10));
		return w;
	endfunction

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		logic [31:0] w;
		int          i;
		board       = new;
		calm        = 1'b0;
		arst_n      = 1'b0;
		word_valid  = 1'b0;
		header_word = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extremes of the header word
		send_header(32'hFFFF_FFFF);
		send_header(32'h0000_0000);

		// Broken sync: first byte, then the low sync bit
		w = build_header(VER_1, LAYER_3, 4'd9, SR_44K, 1'b0);
		send_header(w & ~32'h8000_0000);
		send_header(w & ~32'h0020_0000);

		// One reserved code at a time
		send_header(build_header(VER_BAD, LAYER_3, 4'd9, SR_44K, 1'b0));
		send_header(build_header(VER_1, LAYER_BAD, 4'd9, SR_44K, 1'b0));
		send_header(build_header(VER_1, LAYER_3, BRI_BAD, SR_44K, 1'b0));
		send_header(build_header(VER_1, LAYER_3, 4'd9, SR_BAD, 1'b0));

		// Free format: valid, but no length
		send_header(build_header(VER_1, LAYER_3, BRI_FREE, SR_44K, 1'b1));
		send_header(build_header(VER_25, LAYER_1, BRI_FREE, SR_32K, 1'b0));

		// Every version and layer, including the longest legal frame and short ones
		send_header(build_header(VER_1, LAYER_1, 4'd14, SR_32K, 1'b1));
		send_header(build_header(VER_1, LAYER_2, 4'd14, SR_32K, 1'b0));
		send_header(build_header(VER_1, LAYER_3, 4'd9, SR_44K, 1'b1));
		send_header(build_header(VER_1, LAYER_3, 4'd1, SR_48K, 1'b0));
		send_header(build_header(VER_2, LAYER_1, 4'd1, SR_48K, 1'b0));
		send_header(build_header(VER_2, LAYER_2, 4'd7, SR_44K, 1'b1));
		send_header(build_header(VER_2, LAYER_3, 4'd14, SR_32K, 1'b0));
		send_header(build_header(VER_25, LAYER_1, 4'd14, SR_32K, 1'b1));
		send_header(build_header(VER_25, LAYER_2, 4'd14, SR_32K, 1'b1));
		send_header(build_header(VER_25, LAYER_3, 4'd14, SR_32K, 1'b0));

		// Ignored bits: same frame with protection and low bits all set, all clear
		send_header(32'hFFFB_9BFF);
		send_header(32'hFFFA_9A00);

		drain_sizes();

		// Random headers. Run a stretch with no idling on either side, and
		// drain the pipe every hundred headers.
		for (i = 0; i < RAND_HEADERS; i++) begin
			calm = (i >= 150 && i < 230);
			send_header(rand_header());
			if (i % 100 == 99)
				drain_sizes();
		end
		calm = 1'b0;

		// Wait out the pipeline, then keep watching for strays
		word_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (END_WAIT) @(posedge clk);

		if (board.errors == 0 && board.pending() == 0)
			$display("mpeg_audio_frame_size test passed");
		else
			$display("mpeg_audio_frame_size test failed");
		$finish;
	end

endmodule

// File: filelist.f
hw/rtl/mafs_pkg.sv
hw/rtl/mafs_decode.sv
hw/rtl/mafs_div_cell.sv
hw/rtl/mpeg_audio_frame_size.sv
tb/sv/tb.sv
